// ===== design/vsr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsr_pkg
// Shared types, codes and compare helpers for the voice set reconcile block.
// ---------------------------------------------------------------------------
package vsr_pkg;

  localparam int unsigned ACT_W      = 2;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned SAMP_W     = 32;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned BEND_W     = 14;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned VAL_W      = 14;
  localparam int unsigned MAX_EVENTS = 48;
  localparam int unsigned EVCNT_W    = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RECON   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    EV_OFF  = 2'd0,
    EV_BEND = 2'd1,
    EV_ON   = 2'd2
  } kind_e;

  // Field order doubles as the full-tuple sort order.
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [SAMP_W-1:0] start;
    logic [SAMP_W-1:0] stop;
    logic [NOTE_W-1:0] note;
    logic [BEND_W-1:0] bend;
    logic [VEL_W-1:0]  vel;
  } voice_t;

  localparam int unsigned VOICE_W = $bits(voice_t);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD_SCAN, S_LOAD_WR,
    S_CR_LD, S_CR_CMP, S_DR_LD, S_DR_CMP,
    S_MT_LD, S_MT_CMP, S_DP_LD, S_DP_CMP, S_FR_LD, S_FR_CMP,
    S_OFF, S_BEND, S_ADD_B, S_ADD_N, S_COMMIT, S_REL,
    S_FIN_REC, S_FIN_REL
  } state_e;

  typedef struct packed {
    state_e st;
    logic   accept;
    logic   act;
    logic   last;
  } cmd_t;

  // Continuation key first, then channel, bend, velocity.
  function automatic logic [VOICE_W-1:0] merge_key(input voice_t v);
    merge_key = {v.start, v.stop, v.note, v.ch, v.bend, v.vel};
  endfunction

  function automatic logic key_eq(input voice_t a, input voice_t b);
    key_eq = (a.start == b.start) && (a.stop == b.stop) && (a.note == b.note);
  endfunction

endpackage
`default_nettype wire

// ===== design/voice_set_reconcile.sv =====
`default_nettype none
// A load ends early when a duplicate is found. Reconcile time is set by the pairwise compare
// passes over the voice tables, one compare per cycle.
// Throughput: one item at a time; busy stays high until the item is done.
// Events come out at most one per cycle during emission, registered, and cannot be stalled.
// Reset: asynchronous, active low; both voice tables read as empty after reset.
// ---------------------------------------------------------------------------
// voice_set_reconcile
// Keeps the sounding voice table, reconciles it against a loaded desired
// set or releases it, producing note-off, pitch bend and note-on events.
// ---------------------------------------------------------------------------
module voice_set_reconcile #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [vsr_pkg::ACT_W-1:0]   action_i,
  input  wire logic [vsr_pkg::CH_W-1:0]    voice_channel_i,
  input  wire logic [vsr_pkg::SAMP_W-1:0]  start_sample_i,
  input  wire logic [vsr_pkg::SAMP_W-1:0]  stop_sample_i,
  input  wire logic [vsr_pkg::NOTE_W-1:0]  note_number_i,
  input  wire logic [vsr_pkg::BEND_W-1:0]  bend_value_i,
  input  wire logic [vsr_pkg::VEL_W-1:0]   note_velocity_i,
  output logic                             event_valid_o,
  output logic [vsr_pkg::KIND_W-1:0]       event_kind_o,
  output logic [vsr_pkg::CH_W-1:0]         event_channel_o,
  output logic [vsr_pkg::NOTE_W-1:0]       event_note_o,
  output logic [vsr_pkg::VAL_W-1:0]        event_value_o,
  output logic                             final_event_o
);
  localparam int unsigned CW = $clog2(VOICE_SLOTS+1);

  // controller <-> datapath
  vsr_pkg::cmd_t cmd;
  logic [CW-1:0] i_idx, j_idx, nc, nd;
  logic          load_hit;

  // Sequencer: one step of a pass per cycle.
  vsr_ctrl #(.VOICE_SLOTS(VOICE_SLOTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .action_i   (action_i),
    .nc_i       (nc),
    .nd_i       (nd),
    .load_hit_i (load_hit),
    .cmd_o      (cmd),
    .i_o        (i_idx),
    .j_o        (j_idx),
    .busy       (busy)
  );

  // Tables, compare unit, event buffer and the output transfer register.
  vsr_dp #(.VOICE_SLOTS(VOICE_SLOTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .i_i             (i_idx),
    .j_i             (j_idx),
    .voice_channel_i (voice_channel_i),
    .start_sample_i  (start_sample_i),
    .stop_sample_i   (stop_sample_i),
    .note_number_i   (note_number_i),
    .bend_value_i    (bend_value_i),
    .note_velocity_i (note_velocity_i),
    .nc_o            (nc),
    .nd_o            (nd),
    .load_hit_o      (load_hit),
    .event_valid_o   (event_valid_o),
    .event_kind_o    (event_kind_o),
    .event_channel_o (event_channel_o),
    .event_note_o    (event_note_o),
    .event_value_o   (event_value_o),
    .final_event_o   (final_event_o)
  );

endmodule
`default_nettype wire

// ===== design/vsr_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsr_ctrl
// Sequencer: walks the load scan, the ranking/matching passes, event
// emission and table commit, one step per cycle.
// ---------------------------------------------------------------------------
module vsr_ctrl #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire logic [vsr_pkg::ACT_W-1:0] action_i,
  input  wire logic [$clog2(VOICE_SLOTS+1)-1:0] nc_i,
  input  wire logic [$clog2(VOICE_SLOTS+1)-1:0] nd_i,
  input  wire logic                  load_hit_i,
  output vsr_pkg::cmd_t              cmd_o,
  output logic [$clog2(VOICE_SLOTS+1)-1:0] i_o,
  output logic [$clog2(VOICE_SLOTS+1)-1:0] j_o,
  output logic                       busy
);
  localparam int unsigned CW = $clog2(VOICE_SLOTS+1);

  vsr_pkg::state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [CW:0]   j1;
  logic          act, last, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsr_pkg::S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    act     = 1'b0;
    last    = 1'b0;
    accept  = 1'b0;
    j1      = {1'b0, j_q} + 1'b1;
    case (state_q)
      vsr_pkg::S_IDLE: begin
        if (start) begin
          accept = 1'b1;
          i_d    = '0;
          j_d    = '0;
          case (vsr_pkg::action_e'(action_i))
            vsr_pkg::ACT_LOAD:    state_d = vsr_pkg::S_LOAD_SCAN;
            vsr_pkg::ACT_RECON:   state_d = vsr_pkg::S_CR_LD;
            vsr_pkg::ACT_RELEASE: state_d = vsr_pkg::S_REL;
            default:              state_d = vsr_pkg::S_IDLE;
          endcase
        end
      end
      vsr_pkg::S_LOAD_SCAN: begin
        if (j_q == nd_i) state_d = vsr_pkg::S_LOAD_WR;
        else if (load_hit_i) state_d = vsr_pkg::S_IDLE;
        else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_LOAD_WR: state_d = vsr_pkg::S_IDLE;
      vsr_pkg::S_CR_LD: begin
        if (i_q == nc_i) begin
          state_d = vsr_pkg::S_DR_LD;
          i_d     = '0;
        end else begin
          state_d = vsr_pkg::S_CR_CMP;
          j_d     = '0;
        end
      end
      vsr_pkg::S_CR_CMP: begin
        act  = (j_q < nc_i);
        last = (j1 >= {1'b0, nc_i});
        if (last) begin
          state_d = vsr_pkg::S_CR_LD;
          i_d     = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_DR_LD: begin
        if (i_q == nd_i) begin
          state_d = vsr_pkg::S_MT_LD;
          i_d     = '0;
        end else begin
          state_d = vsr_pkg::S_DR_CMP;
          j_d     = '0;
        end
      end
      vsr_pkg::S_DR_CMP: begin
        act  = (j_q < nd_i);
        last = (j1 >= {1'b0, nd_i});
        if (last) begin
          state_d = vsr_pkg::S_DR_LD;
          i_d     = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_MT_LD: begin
        if (i_q == nd_i) begin
          state_d = vsr_pkg::S_DP_LD;
          i_d     = '0;
        end else begin
          state_d = vsr_pkg::S_MT_CMP;
          j_d     = '0;
        end
      end
      vsr_pkg::S_MT_CMP: begin
        // runs at least once so an empty sounding table still records "no match"
        act  = (j_q < nc_i);
        last = (j1 >= {1'b0, nc_i});
        if (last) begin
          state_d = vsr_pkg::S_MT_LD;
          i_d     = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_DP_LD: begin
        if (i_q == nd_i) begin
          state_d = vsr_pkg::S_FR_LD;
          i_d     = '0;
        end else begin
          state_d = vsr_pkg::S_DP_CMP;
          j_d     = '0;
        end
      end
      vsr_pkg::S_DP_CMP: begin
        act  = (j_q < nd_i);
        last = (j1 >= {1'b0, nd_i});
        if (last) begin
          state_d = vsr_pkg::S_DP_LD;
          i_d     = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_FR_LD: begin
        if (i_q == nd_i) begin
          state_d = vsr_pkg::S_OFF;
          i_d     = '0;
        end else begin
          state_d = vsr_pkg::S_FR_CMP;
          j_d     = '0;
        end
      end
      vsr_pkg::S_FR_CMP: begin
        act  = (j_q < nd_i);
        last = (j1 >= {1'b0, nd_i});
        if (last) begin
          state_d = vsr_pkg::S_FR_LD;
          i_d     = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      vsr_pkg::S_OFF: begin
        act = (i_q < nc_i);
        if (act) i_d = i_q + 1'b1;
        else begin
          state_d = vsr_pkg::S_BEND;
          i_d     = '0;
        end
      end
      vsr_pkg::S_BEND: begin
        act = (i_q < nd_i);
        if (act) i_d = i_q + 1'b1;
        else begin
          state_d = vsr_pkg::S_ADD_B;
          i_d     = '0;
        end
      end
      vsr_pkg::S_ADD_B: begin
        if (i_q == nd_i) begin
          state_d = vsr_pkg::S_COMMIT;
          i_d     = '0;
        end else begin
          act     = 1'b1;
          state_d = vsr_pkg::S_ADD_N;
        end
      end
      vsr_pkg::S_ADD_N: begin
        act     = 1'b1;
        i_d     = i_q + 1'b1;
        state_d = vsr_pkg::S_ADD_B;
      end
      vsr_pkg::S_COMMIT: begin
        act = (i_q < nd_i);
        if (act) i_d = i_q + 1'b1;
        else state_d = vsr_pkg::S_FIN_REC;
      end
      vsr_pkg::S_REL: begin
        act = (i_q < nc_i);
        if (act) i_d = i_q + 1'b1;
        else state_d = vsr_pkg::S_FIN_REL;
      end
      vsr_pkg::S_FIN_REC: state_d = vsr_pkg::S_IDLE;
      vsr_pkg::S_FIN_REL: state_d = vsr_pkg::S_IDLE;
      default:            state_d = vsr_pkg::S_IDLE;
    endcase
  end

  assign cmd_o.st     = state_q;
  assign cmd_o.accept = accept;
  assign cmd_o.act    = act;
  assign cmd_o.last   = last;
  assign i_o          = i_q;
  assign j_o          = j_q;
  assign busy         = (state_q != vsr_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== design/vsr_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsr_dp
// Voice tables, rank/match bookkeeping, event generation and output register.
// ---------------------------------------------------------------------------
module vsr_dp #(
  parameter int unsigned VOICE_SLOTS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire vsr_pkg::cmd_t          cmd_i,
  input  wire logic [$clog2(VOICE_SLOTS+1)-1:0] i_i,
  input  wire logic [$clog2(VOICE_SLOTS+1)-1:0] j_i,
  input  wire logic [vsr_pkg::CH_W-1:0]   voice_channel_i,
  input  wire logic [vsr_pkg::SAMP_W-1:0] start_sample_i,
  input  wire logic [vsr_pkg::SAMP_W-1:0] stop_sample_i,
  input  wire logic [vsr_pkg::NOTE_W-1:0] note_number_i,
  input  wire logic [vsr_pkg::BEND_W-1:0] bend_value_i,
  input  wire logic [vsr_pkg::VEL_W-1:0]  note_velocity_i,
  output logic [$clog2(VOICE_SLOTS+1)-1:0] nc_o,
  output logic [$clog2(VOICE_SLOTS+1)-1:0] nd_o,
  output logic                        load_hit_o,
  output logic                        event_valid_o,
  output logic [vsr_pkg::KIND_W-1:0]  event_kind_o,
  output logic [vsr_pkg::CH_W-1:0]    event_channel_o,
  output logic [vsr_pkg::NOTE_W-1:0]  event_note_o,
  output logic [vsr_pkg::VAL_W-1:0]   event_value_o,
  output logic                        final_event_o
);
  localparam int unsigned CW = $clog2(VOICE_SLOTS+1);
  localparam int unsigned IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

  vsr_pkg::voice_t snd_q [VOICE_SLOTS];
  vsr_pkg::voice_t pnd_q [VOICE_SLOTS];
  logic [IW-1:0] cord_q [VOICE_SLOTS];
  logic [IW-1:0] dord_q [VOICE_SLOTS];
  logic [IW-1:0] frank_q [VOICE_SLOTS];
  logic [CW-1:0] occc_q [VOICE_SLOTS];
  logic [CW-1:0] occd_q [VOICE_SLOTS];
  logic [vsr_pkg::CH_W-1:0] newch_q [VOICE_SLOTS];
  logic [VOICE_SLOTS-1:0] dm_q, dvd_q, dbd_q, dup_q, cm_q, cvd_q;

  logic [CW-1:0] nc_q, nd_q, ndist_q;
  vsr_pkg::voice_t in_q, ri_q;
  logic [CW-1:0] ri_occ_q, acc_cnt_q, acc_occ_q;
  logic acc_flag_q, m_vd_q, m_bd_q;
  logic [vsr_pkg::CH_W-1:0] m_ch_q;

  logic [IW-1:0] ix, jx, cur_ax, des_ax;
  vsr_pkg::voice_t cur_rec, des_rec, des_mod;
  logic lt, oc, hit;
  logic [CW-1:0] cnt_nx, occ_nx;
  logic flag_nx;

  // held event (one behind, so the last one can carry the final mark)
  logic hv_q;
  logic [vsr_pkg::EVCNT_W-1:0] ev_cnt_q;
  logic [vsr_pkg::KIND_W-1:0] h_kind_q, g_kind;
  logic [vsr_pkg::CH_W-1:0]   h_ch_q, g_ch;
  logic [vsr_pkg::NOTE_W-1:0] h_note_q, g_note;
  logic [vsr_pkg::VAL_W-1:0]  h_val_q, g_val;
  logic gen, take, flush;
  logic ov_q, of_q;
  logic [vsr_pkg::KIND_W-1:0] ok_q;
  logic [vsr_pkg::CH_W-1:0]   och_q;
  logic [vsr_pkg::NOTE_W-1:0] on_q;
  logic [vsr_pkg::VAL_W-1:0]  oval_q;

  assign ix = i_i[IW-1:0];
  assign jx = j_i[IW-1:0];

  always_comb begin
    case (cmd_i.st)
      vsr_pkg::S_CR_CMP, vsr_pkg::S_MT_CMP: cur_ax = jx;
      vsr_pkg::S_OFF:                       cur_ax = cord_q[ix];
      default:                              cur_ax = ix;
    endcase
    case (cmd_i.st)
      vsr_pkg::S_DR_CMP, vsr_pkg::S_DP_CMP, vsr_pkg::S_FR_CMP,
      vsr_pkg::S_LOAD_SCAN:                 des_ax = jx;
      vsr_pkg::S_BEND, vsr_pkg::S_ADD_B,
      vsr_pkg::S_ADD_N:                     des_ax = dord_q[ix];
      default:                              des_ax = ix;
    endcase
  end

  always_comb begin
    cur_rec    = snd_q[cur_ax];
    des_rec    = pnd_q[des_ax];
    des_mod    = des_rec;
    des_mod.ch = newch_q[des_ax];
  end

  assign load_hit_o = (des_rec == in_q);

  // one compare per step, chosen by pass
  always_comb begin
    lt  = 1'b0;
    oc  = 1'b0;
    hit = 1'b0;
    case (cmd_i.st)
      vsr_pkg::S_CR_CMP: begin
        lt = vsr_pkg::merge_key(cur_rec) < vsr_pkg::merge_key(ri_q);
        oc = lt && vsr_pkg::key_eq(cur_rec, ri_q);
      end
      vsr_pkg::S_DR_CMP: begin
        lt = vsr_pkg::merge_key(des_rec) < vsr_pkg::merge_key(ri_q);
        oc = lt && vsr_pkg::key_eq(des_rec, ri_q);
      end
      vsr_pkg::S_MT_CMP:
        hit = cmd_i.act && vsr_pkg::key_eq(cur_rec, ri_q) && (occc_q[jx] == ri_occ_q);
      vsr_pkg::S_DP_CMP:
        hit = (j_i < i_i) && (des_mod == ri_q);
      vsr_pkg::S_FR_CMP:
        lt = !dup_q[jx] && (des_mod < ri_q);
      default: ;
    endcase
    cnt_nx  = acc_cnt_q + {{(CW-1){1'b0}}, lt};
    occ_nx  = acc_occ_q + {{(CW-1){1'b0}}, oc};
    flag_nx = acc_flag_q | hit;
  end

  // event source
  always_comb begin
    gen    = 1'b0;
    g_kind = vsr_pkg::EV_OFF;
    g_ch   = cur_rec.ch;
    g_note = cur_rec.note;
    g_val  = '0;
    case (cmd_i.st)
      vsr_pkg::S_OFF: gen = cmd_i.act && (!cm_q[cur_ax] || cvd_q[cur_ax]);
      vsr_pkg::S_REL: gen = cmd_i.act;
      vsr_pkg::S_BEND, vsr_pkg::S_ADD_B: begin
        if (cmd_i.st == vsr_pkg::S_BEND)
          gen = cmd_i.act && dm_q[des_ax] && !dvd_q[des_ax] && dbd_q[des_ax];
        else
          gen = cmd_i.act && (!dm_q[des_ax] || dvd_q[des_ax]);
        g_kind = vsr_pkg::EV_BEND;
        g_ch   = des_mod.ch;
        g_note = '0;
        g_val  = des_mod.bend;
      end
      vsr_pkg::S_ADD_N: begin
        gen    = cmd_i.act && (!dm_q[des_ax] || dvd_q[des_ax]);
        g_kind = vsr_pkg::EV_ON;
        g_ch   = des_mod.ch;
        g_note = des_mod.note;
        g_val  = {{(vsr_pkg::VAL_W-vsr_pkg::VEL_W){1'b0}}, des_mod.vel};
      end
      default: ;
    endcase
    take  = gen && (ev_cnt_q != vsr_pkg::EVCNT_W'(vsr_pkg::MAX_EVENTS));
    flush = (cmd_i.st == vsr_pkg::S_FIN_REC) || (cmd_i.st == vsr_pkg::S_FIN_REL);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q     <= '0;
      nd_q     <= '0;
      ndist_q  <= '0;
      hv_q     <= 1'b0;
      ev_cnt_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      ov_q <= (take || flush) && hv_q;
      if (cmd_i.accept) begin
        ndist_q  <= '0;
        ev_cnt_q <= '0;
      end
      if (take) begin
        hv_q     <= 1'b1;
        ev_cnt_q <= ev_cnt_q + 1'b1;
      end
      if (flush) hv_q <= 1'b0;
      if (cmd_i.st == vsr_pkg::S_LOAD_WR && nd_q != CW'(VOICE_SLOTS))
        nd_q <= nd_q + 1'b1;
      if (cmd_i.st == vsr_pkg::S_DP_CMP && cmd_i.last && !flag_nx)
        ndist_q <= ndist_q + 1'b1;
      if (cmd_i.st == vsr_pkg::S_FIN_REC) begin
        nc_q <= ndist_q;
        nd_q <= '0;
      end
      if (cmd_i.st == vsr_pkg::S_FIN_REL) nc_q <= '0;
    end
  end

  // tables and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q  <= '{ch: voice_channel_i, start: start_sample_i, stop: stop_sample_i,
                 note: note_number_i, bend: bend_value_i, vel: note_velocity_i};
      cm_q  <= '0;
      cvd_q <= '0;
    end
    if (take) begin
      h_kind_q <= g_kind;
      h_ch_q   <= g_ch;
      h_note_q <= g_note;
      h_val_q  <= g_val;
    end
    if (take || flush) begin
      ok_q   <= h_kind_q;
      och_q  <= h_ch_q;
      on_q   <= h_note_q;
      oval_q <= h_val_q;
      of_q   <= flush;
    end
    case (cmd_i.st)
      vsr_pkg::S_CR_LD, vsr_pkg::S_DR_LD, vsr_pkg::S_MT_LD,
      vsr_pkg::S_DP_LD, vsr_pkg::S_FR_LD: begin
        acc_cnt_q  <= '0;
        acc_occ_q  <= '0;
        acc_flag_q <= 1'b0;
        ri_occ_q   <= occd_q[des_ax];
        case (cmd_i.st)
          vsr_pkg::S_CR_LD:                    ri_q <= cur_rec;
          vsr_pkg::S_DR_LD, vsr_pkg::S_MT_LD:  ri_q <= des_rec;
          default:                             ri_q <= des_mod;
        endcase
      end
      vsr_pkg::S_CR_CMP, vsr_pkg::S_DR_CMP, vsr_pkg::S_FR_CMP, vsr_pkg::S_DP_CMP: begin
        acc_cnt_q  <= cnt_nx;
        acc_occ_q  <= occ_nx;
        acc_flag_q <= flag_nx;
        if (cmd_i.last) begin
          case (cmd_i.st)
            vsr_pkg::S_CR_CMP: begin
              cord_q[cnt_nx[IW-1:0]] <= ix;
              occc_q[ix]             <= occ_nx;
            end
            vsr_pkg::S_DR_CMP: begin
              dord_q[cnt_nx[IW-1:0]] <= ix;
              occd_q[ix]             <= occ_nx;
            end
            vsr_pkg::S_FR_CMP: frank_q[ix] <= cnt_nx[IW-1:0];
            default:           dup_q[ix]   <= flag_nx;
          endcase
        end
      end
      vsr_pkg::S_MT_CMP: begin
        acc_flag_q <= flag_nx;
        if (hit) begin
          m_ch_q    <= cur_rec.ch;
          m_vd_q    <= (cur_rec.vel != ri_q.vel);
          m_bd_q    <= (cur_rec.bend != ri_q.bend);
          cm_q[jx]  <= 1'b1;
          cvd_q[jx] <= (cur_rec.vel != ri_q.vel);
        end
        if (cmd_i.last) begin
          dm_q[ix] <= flag_nx;
          if (hit) begin
            newch_q[ix] <= cur_rec.ch;
            dvd_q[ix]   <= (cur_rec.vel != ri_q.vel);
            dbd_q[ix]   <= (cur_rec.bend != ri_q.bend);
          end else if (acc_flag_q) begin
            newch_q[ix] <= m_ch_q;
            dvd_q[ix]   <= m_vd_q;
            dbd_q[ix]   <= m_bd_q;
          end else begin
            newch_q[ix] <= ri_q.ch;
            dvd_q[ix]   <= 1'b0;
            dbd_q[ix]   <= 1'b0;
          end
        end
      end
      vsr_pkg::S_LOAD_WR:
        if (nd_q != CW'(VOICE_SLOTS)) pnd_q[nd_q[IW-1:0]] <= in_q;
      vsr_pkg::S_COMMIT:
        if (cmd_i.act && !dup_q[ix]) snd_q[frank_q[ix]] <= des_mod;
      default: ;
    endcase
  end

  assign nc_o            = nc_q;
  assign nd_o            = nd_q;
  assign event_valid_o   = ov_q;
  assign event_kind_o    = ok_q;
  assign event_channel_o = och_q;
  assign event_note_o    = on_q;
  assign event_value_o   = oval_q;
  assign final_event_o   = of_q;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives load, reconcile, release-all and undefined commands into
// voice_set_reconcile, predicts the event stream of every accepted command
// and checks each strobed event field by field against the oldest
// prediction. Sender idling changes by phase.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic [vsr_pkg::ACT_W-1:0] ACT_UNDEF = 2'd3;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [vsr_pkg::ACT_W-1:0] act;
    vsr_pkg::voice_t           v;
  } voice_cmd_t;

  typedef struct packed {
    logic [vsr_pkg::KIND_W-1:0] kind;
    logic [vsr_pkg::CH_W-1:0]   ch;
    logic [vsr_pkg::NOTE_W-1:0] note;
    logic [vsr_pkg::VAL_W-1:0]  val;
    logic                       fin;
  } midi_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [vsr_pkg::ACT_W-1:0]  action_i = '0;
  logic [vsr_pkg::CH_W-1:0]   voice_channel_i = '0;
  logic [vsr_pkg::SAMP_W-1:0] start_sample_i = '0;
  logic [vsr_pkg::SAMP_W-1:0] stop_sample_i = '0;
  logic [vsr_pkg::NOTE_W-1:0] note_number_i = '0;
  logic [vsr_pkg::BEND_W-1:0] bend_value_i = '0;
  logic [vsr_pkg::VEL_W-1:0]  note_velocity_i = '0;
  logic                       event_valid_o;
  logic [vsr_pkg::KIND_W-1:0] event_kind_o;
  logic [vsr_pkg::CH_W-1:0]   event_channel_o;
  logic [vsr_pkg::NOTE_W-1:0] event_note_o;
  logic [vsr_pkg::VAL_W-1:0]  event_value_o;
  logic                       final_event_o;

  voice_set_reconcile #(.VOICE_SLOTS(SLOTS)) dut (
    .clk_i, .rst_ni, .start, .busy,
    .action_i, .voice_channel_i, .start_sample_i, .stop_sample_i,
    .note_number_i, .bend_value_i, .note_velocity_i,
    .event_valid_o, .event_kind_o, .event_channel_o, .event_note_o,
    .event_value_o, .final_event_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  voice_cmd_t  cmd_queue[$];
  midi_event_t expected_events[$];
  voice_cmd_t  presented;
  int errors = 0;
  int accepted = 0;
  int stall_cycles = 0;

  // Predictor state: the sounding table and the loaded (desired) set.
  vsr_pkg::voice_t sounding[SLOTS];
  vsr_pkg::voice_t loaded[SLOTS];
  int     sounding_n = 0;
  int     loaded_n = 0;
  // Scratch space for the sorts.
  vsr_pkg::voice_t sort_buf[SLOTS];

  function automatic logic [vsr_pkg::VOICE_W-1:0] merge_order(vsr_pkg::voice_t v);
    return {v.start, v.stop, v.note, v.ch, v.bend, v.vel};
  endfunction

  function automatic logic [vsr_pkg::SAMP_W*2+vsr_pkg::NOTE_W-1:0] cont_key(
      vsr_pkg::voice_t v);
    return {v.start, v.stop, v.note};
  endfunction

  // Stable insertion sort of sort_buf; full order is the packed voice itself.
  task automatic sort_voices(int n, bit full_order);
    vsr_pkg::voice_t t;
    int j;
    for (int i = 1; i < n; i++) begin
      t = sort_buf[i];
      j = i;
      while (j > 0 && (full_order ? (t < sort_buf[j-1])
                                  : (merge_order(t) < merge_order(sort_buf[j-1])))) begin
        sort_buf[j] = sort_buf[j-1];
        j--;
      end
      sort_buf[j] = t;
    end
  endtask

  task automatic push_event(logic [vsr_pkg::KIND_W-1:0] kind, logic [vsr_pkg::CH_W-1:0] ch,
                            logic [vsr_pkg::NOTE_W-1:0] note,
                            logic [vsr_pkg::VAL_W-1:0] val, int base);
    midi_event_t e;
    if (expected_events.size() - base < vsr_pkg::MAX_EVENTS) begin
      e = '{kind: kind, ch: ch, note: note, val: val, fin: 1'b0};
      expected_events.insert(expected_events.size(), e);
    end
  endtask

  task automatic reconcile_sets(int base);
    vsr_pkg::voice_t cur[SLOTS], des[SLOTS], offs[SLOTS], bends[SLOTS];
    vsr_pkg::voice_t adds[SLOTS], nxt[SLOTS];
    vsr_pkg::voice_t d;
    int nr, nb, na, nn, ci, di, order;
    bit dup;
    nr = 0; nb = 0; na = 0; nn = 0; ci = 0; di = 0;
    for (int i = 0; i < sounding_n; i++) sort_buf[i] = sounding[i];
    sort_voices(sounding_n, 1'b0);
    for (int i = 0; i < sounding_n; i++) cur[i] = sort_buf[i];
    for (int i = 0; i < loaded_n; i++) sort_buf[i] = loaded[i];
    sort_voices(loaded_n, 1'b0);
    for (int i = 0; i < loaded_n; i++) des[i] = sort_buf[i];

    while (ci < sounding_n || di < loaded_n) begin
      if (di >= loaded_n) order = -1;
      else if (ci >= sounding_n) order = 1;
      else if (cont_key(cur[ci]) < cont_key(des[di])) order = -1;
      else if (cont_key(cur[ci]) > cont_key(des[di])) order = 1;
      else order = 0;
      if (order < 0) begin
        offs[nr++] = cur[ci++];
      end else begin
        d = des[di++];
        if (order > 0) begin
          adds[na++] = d;
        end else begin
          // Continuing voice keeps the channel it already sounds on.
          d.ch = cur[ci].ch;
          if (d.vel != cur[ci].vel) begin
            offs[nr++] = cur[ci];
            adds[na++] = d;
          end else if (d.bend != cur[ci].bend) begin
            bends[nb++] = d;
          end
          ci++;
        end
        dup = 1'b0;
        for (int k = 0; k < nn; k++) if (nxt[k] == d) dup = 1'b1;
        if (!dup) nxt[nn++] = d;
      end
    end

    for (int i = 0; i < nr; i++)
      push_event(vsr_pkg::EV_OFF, offs[i].ch, offs[i].note, '0, base);
    for (int i = 0; i < nb; i++)
      push_event(vsr_pkg::EV_BEND, bends[i].ch, '0, bends[i].bend, base);
    for (int i = 0; i < na; i++) begin
      push_event(vsr_pkg::EV_BEND, adds[i].ch, '0, adds[i].bend, base);
      push_event(vsr_pkg::EV_ON, adds[i].ch, adds[i].note, vsr_pkg::VAL_W'(adds[i].vel),
                 base);
    end

    for (int i = 0; i < nn; i++) sort_buf[i] = nxt[i];
    sort_voices(nn, 1'b1);
    for (int i = 0; i < nn; i++) sounding[i] = sort_buf[i];
    sounding_n = nn;
    loaded_n = 0;
  endtask

  task automatic predict_events(voice_cmd_t c);
    int base;
    bit dup;
    midi_event_t last_ev;
    base = expected_events.size();
    case (c.act)
      vsr_pkg::ACT_LOAD: begin
        dup = 1'b0;
        for (int i = 0; i < loaded_n; i++) if (loaded[i] == c.v) dup = 1'b1;
        if (!dup && loaded_n < SLOTS) loaded[loaded_n++] = c.v;
      end
      vsr_pkg::ACT_RECON: reconcile_sets(base);
      vsr_pkg::ACT_RELEASE: begin
        for (int i = 0; i < sounding_n; i++)
          push_event(vsr_pkg::EV_OFF, sounding[i].ch, sounding[i].note, '0, base);
        sounding_n = 0;
      end
      default: ;
    endcase
    if (expected_events.size() > base) begin
      last_ev = expected_events[$];
      last_ev.fin = 1'b1;
      expected_events[expected_events.size()-1] = last_ev;
    end
  endtask

  // Sender idling per phase: none, heavy, none (receiver cannot stall), light.
  function automatic int gap_percent(int n);
    if (n < 30) return 0;
    if (n < 55) return 85;
    if (n < 80) return 0;
    return 23;
  endfunction

  // Driver: a transfer happens when start is high and busy low at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_events(presented);
        accepted++;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= gap_percent(accepted)) begin
          presented        = cmd_queue.pop_front();
          start           <= 1'b1;
          action_i        <= presented.act;
          voice_channel_i <= presented.v.ch;
          start_sample_i  <= presented.v.start;
          stop_sample_i   <= presented.v.stop;
          note_number_i   <= presented.v.note;
          bend_value_i    <= presented.v.bend;
          note_velocity_i <= presented.v.vel;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    midi_event_t got, want;
    if (rst_ni) begin
      if ((start && !busy) || event_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Mismatches found");
        $finish;
      end
      if (event_valid_o) begin
        got = '{kind: event_kind_o, ch: event_channel_o, note: event_note_o,
                val: event_value_o, fin: final_event_o};
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected event kind=%0d ch=%0d note=%0d val=%0d fin=%0d",
                   $time, got.kind, got.ch, got.note, got.val, got.fin);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: event mismatch expected kind=%0d ch=%0d note=%0d val=%0d fin=%0d",
                     $time, want.kind, want.ch, want.note, want.val, want.fin);
            $display("%0t:                actual   kind=%0d ch=%0d note=%0d val=%0d fin=%0d",
                     $time, got.kind, got.ch, got.note, got.val, got.fin);
          end
        end
      end
    end
  end

  function automatic logic [vsr_pkg::SAMP_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return vsr_pkg::SAMP_W'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  function automatic vsr_pkg::voice_t rand_voice();
    vsr_pkg::voice_t v;
    v.ch    = vsr_pkg::CH_W'($urandom_range(9) == 0 ? $urandom_range(31)
                                                    : $urandom_range(16, 1));
    v.start = rand_sample();
    v.stop  = rand_sample();
    v.note  = vsr_pkg::NOTE_W'($urandom_range(127));
    v.bend  = vsr_pkg::BEND_W'($urandom_range(16383));
    v.vel   = vsr_pkg::VEL_W'($urandom_range(127));
    return v;
  endfunction

  task automatic add_cmd(logic [vsr_pkg::ACT_W-1:0] act, vsr_pkg::voice_t v);
    voice_cmd_t c;
    c.act = act;
    c.v   = v;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  initial begin
    vsr_pkg::voice_t v0, v1, v2, v, pool[8];
    int n_loads;
    v0 = '{ch: 5'd1, start: '0, stop: '0, note: '0, bend: '0, vel: '0};
    v1 = '{ch: 5'd31, start: '1, stop: '1, note: '1, bend: '1, vel: '1};
    v2 = '{ch: 5'd16, start: 32'h8000_0000, stop: 32'h7fff_ffff, note: 7'd64,
           bend: 14'h2000, vel: 7'd100};

    // Directed: empty table, undefined action, extremes, duplicate load.
    add_cmd(vsr_pkg::ACT_RELEASE, v0);
    add_cmd(vsr_pkg::ACT_RECON, v0);
    add_cmd(ACT_UNDEF, v1);
    add_cmd(vsr_pkg::ACT_LOAD, v0);
    add_cmd(vsr_pkg::ACT_LOAD, v1);
    add_cmd(vsr_pkg::ACT_LOAD, v1);
    add_cmd(vsr_pkg::ACT_LOAD, v2);
    add_cmd(vsr_pkg::ACT_RECON, v0);
    // Continuations: velocity change, bend change, unchanged, new channel.
    v = v0; v.vel = 7'd1; add_cmd(vsr_pkg::ACT_LOAD, v);
    v = v1; v.bend = 14'd0; v.ch = 5'd3; add_cmd(vsr_pkg::ACT_LOAD, v);
    add_cmd(vsr_pkg::ACT_LOAD, v2);
    add_cmd(vsr_pkg::ACT_RECON, v0);
    v = v2; v.ch = 5'd2; add_cmd(vsr_pkg::ACT_LOAD, v);
    v = v2; v.ch = 5'd9; add_cmd(vsr_pkg::ACT_LOAD, v);
    add_cmd(vsr_pkg::ACT_RECON, v0);
    add_cmd(vsr_pkg::ACT_RELEASE, v0);
    add_cmd(vsr_pkg::ACT_RECON, v0);

    // Random: mostly load sets that reuse a small pool so voices continue.
    foreach (pool[i]) pool[i] = rand_voice();
    while (cmd_queue.size() < 100) begin
      if ($urandom_range(9) == 0) pool[$urandom_range(7)] = rand_voice();
      case ($urandom_range(19))
        0: add_cmd(vsr_pkg::ACT_RELEASE, rand_voice());
        1: add_cmd(ACT_UNDEF, rand_voice());
        2: add_cmd(vsr_pkg::ACT_RECON, rand_voice());
        default: begin
          n_loads = ($urandom_range(9) == 0) ? $urandom_range(18, 15) : $urandom_range(6);
          for (int i = 0; i < n_loads; i++) begin
            if ($urandom_range(2) == 0) begin
              v = rand_voice();
            end else begin
              v = pool[$urandom_range(7)];
              case ($urandom_range(4))
                0: v.vel  = vsr_pkg::VEL_W'($urandom_range(127));
                1: v.bend = vsr_pkg::BEND_W'($urandom_range(16383));
                2: v.ch   = vsr_pkg::CH_W'($urandom_range(16, 1));
                default: ;
              endcase
            end
            add_cmd(vsr_pkg::ACT_LOAD, v);
          end
          add_cmd(vsr_pkg::ACT_RECON, v0);
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() > 0 || start || busy || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (expected_events.size() > 0)
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    if (errors == 0 && expected_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
